@@ hw/rtl/riff_pkg.sv @@
// Shared types and constants for the RIFF chunk stream parser.
package riff_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 144;
  localparam int EVENT_W     = 3;
  localparam int DEPTH_OUT_W = 4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;

  localparam logic [EVENT_W-1:0] EV_FILE_FORM  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_LIST_START = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CHUNK      = 3'd2;
  localparam logic [EVENT_W-1:0] EV_DATA       = 3'd3;
  localparam logic [EVENT_W-1:0] EV_NOT_RIFF   = 3'd4;

  localparam logic [0:0] KIND_BYTE   = 1'b0;
  localparam logic [0:0] KIND_RESYNC = 1'b1;

  localparam logic [3:0]  FILE_HDR_LAST  = 4'd11;
  localparam logic [3:0]  CHUNK_HDR_LAST = 4'd7;
  localparam logic [3:0]  LIST_HDR_LAST  = 4'd11;
  localparam logic [31:0] FILE_HDR_LEN   = 32'd12;
  localparam logic [31:0] CHUNK_HDR_LEN  = 32'd8;
  localparam logic [31:0] LIST_HDR_LEN   = 32'd12;

  typedef struct packed {
    logic [EVENT_W-1:0]     event_res;
    logic [31:0]            fourcc;
    logic [31:0]            chunk_size;
    logic [31:0]            list_form;
    logic [31:0]            data_position;
    logic [DEPTH_OUT_W-1:0] nesting_depth;
    logic [7:0]             data_value;
    logic                   last_of_chunk;
    logic                   stack_overflow;
  } result_t;

endpackage

@@ hw/rtl/riff_chunk_stream_parser.sv @@
// RIFF chunk stream parser: header decode, LIST end stack and payload streaming.
//
// Usage:
//   The s_axis channel carries one request per cycle while tready is high: tuser = 0
//   is a stream byte in tdata[7:0], tuser = 1 is a resync with the position of the next
//   header in tdata[39:8]. Each request gives zero or one result on m_axis: file form,
//   list start, chunk start, chunk data byte (tlast on the final payload byte) or not
//   RIFF, with the event code in tuser.
//   Results are registered in the output register, or in the skid register on a stall.
//   Throughput is one request per cycle while the skid register is not full; header bytes,
//   stack pops and payload counters are all settled in the cycle after the input handshake.
//   The LIST stack holds LIST_STACK_DEPTH end offsets; all finished entries are
//   popped at once with one comparator per entry.
//   When m_axis stalls, one further result is held in a skid register and s_axis
//   keeps taking requests; tready drops only while the skid register is full.
//   Reset (rst, synchronous) empties the output and skid registers and the stack and
//   returns to the file header check at position zero.
module riff_chunk_stream_parser #(
  parameter int LIST_STACK_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] stream_byte, [39:8] resync_position
  input  logic [riff_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] kind
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] fourcc, [63:32] chunk_size, [95:64] list_form, [127:96] data_position,
  // [131:128] nesting_depth, [139:132] data_value, [140] stack_overflow
  output logic [riff_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [2:0] event_res
  output logic [riff_pkg::EVENT_W-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int CW = $clog2(LIST_STACK_DEPTH + 1);
  localparam int IW = (LIST_STACK_DEPTH > 1) ? $clog2(LIST_STACK_DEPTH) : 1;

  localparam logic [2:0] PH_FILE = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_PAD  = 3'd3;
  localparam logic [2:0] PH_ERR  = 3'd4;

  logic [2:0]    phase, phase_next;
  logic [31:0]   next_header_position, next_header_position_next;
  logic [3:0]    header_count, header_count_next;
  logic [31:0]   payload_left, payload_left_next;
  logic          pad_pending, pad_pending_next;
  logic [CW-1:0] stack_count, stack_count_next;
  logic [7:0]    header_bytes [12];
  logic [32:0]   list_end_stack [LIST_STACK_DEPTH];

  logic          hb_we;
  logic          push_en;
  logic [32:0]   push_val;
  logic [CW-1:0] pop_count;
  logic          res_valid;
  riff_pkg::result_t res;
  riff_pkg::result_t out_reg, skid_reg;
  logic          skid_valid;

  logic          accept, out_fire;
  logic          kind;
  logic [7:0]    b;
  logic [31:0]   rpos;
  logic [31:0]   w0, w4, size_hdr, form_last, hpos;
  logic [CW+3:0] depth_ext;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign kind     = s_axis_tuser;
  assign b        = s_axis_tdata[7:0];
  assign rpos     = s_axis_tdata[39:8];
  assign hpos     = next_header_position;

  assign w0        = {header_bytes[3], header_bytes[2], header_bytes[1], header_bytes[0]};
  assign w4        = {header_bytes[7], header_bytes[6], header_bytes[5], header_bytes[4]};
  assign size_hdr  = {b, header_bytes[6], header_bytes[5], header_bytes[4]};
  assign form_last = {b, header_bytes[10], header_bytes[9], header_bytes[8]};

  always_comb begin
    pop_count = '0;
    for (int i = 0; i < LIST_STACK_DEPTH; i++) begin
      if ((CW'(i) < stack_count) && (list_end_stack[i] > {1'b0, hpos})) begin
        pop_count = CW'(i + 1);
      end
    end
  end

  assign depth_ext = {4'b0, stack_count_next};

  always_comb begin
    phase_next                = phase;
    next_header_position_next = next_header_position;
    header_count_next         = header_count;
    payload_left_next         = payload_left;
    pad_pending_next          = pad_pending;
    stack_count_next          = stack_count;
    hb_we                     = 1'b0;
    push_en                   = 1'b0;
    push_val                  = {1'b0, hpos} + {1'b0, riff_pkg::CHUNK_HDR_LEN} + {1'b0, w4};
    res_valid                 = 1'b0;
    res                       = '0;

    if (accept) begin
      if (kind == riff_pkg::KIND_RESYNC) begin
        header_count_next = '0;
        payload_left_next = '0;
        pad_pending_next  = 1'b0;
        if (rpos == 32'd0) begin
          next_header_position_next = '0;
          stack_count_next          = '0;
          phase_next                = PH_FILE;
        end else if (rpos[0]) begin
          next_header_position_next = rpos + 32'd1;
          phase_next                = PH_PAD;
        end else begin
          next_header_position_next = rpos;
          phase_next                = PH_HDR;
        end
      end else begin
        unique case (phase)
          PH_FILE: begin
            hb_we             = 1'b1;
            header_count_next = header_count + 4'd1;
            if (header_count == riff_pkg::FILE_HDR_LAST) begin
              header_count_next = '0;
              res_valid         = 1'b1;
              if (w0 != riff_pkg::TAG_RIFF) begin
                phase_next    = PH_ERR;
                res.event_res = riff_pkg::EV_NOT_RIFF;
              end else begin
                next_header_position_next = riff_pkg::FILE_HDR_LEN;
                phase_next                = PH_HDR;
                res.event_res             = riff_pkg::EV_FILE_FORM;
                res.fourcc                = form_last;
                res.chunk_size            = w4;
                res.data_position         = riff_pkg::FILE_HDR_LEN;
              end
            end
          end
          PH_HDR: begin
            hb_we             = 1'b1;
            header_count_next = header_count + 4'd1;
            if (header_count == riff_pkg::CHUNK_HDR_LAST) begin
              stack_count_next = pop_count;
              if (w0 != riff_pkg::TAG_LIST) begin
                header_count_next         = '0;
                next_header_position_next = hpos + riff_pkg::CHUNK_HDR_LEN + size_hdr +
                                            {31'b0, size_hdr[0]};
                payload_left_next         = size_hdr;
                pad_pending_next          = size_hdr[0];
                phase_next                = (size_hdr != 32'd0) ? PH_DATA : PH_HDR;
                res_valid                 = 1'b1;
                res.event_res             = riff_pkg::EV_CHUNK;
                res.fourcc                = w0;
                res.chunk_size            = size_hdr;
                res.data_position         = hpos + riff_pkg::CHUNK_HDR_LEN;
              end
            end else if (header_count == riff_pkg::LIST_HDR_LAST) begin
              header_count_next         = '0;
              next_header_position_next = hpos + riff_pkg::LIST_HDR_LEN;
              res_valid                 = 1'b1;
              res.event_res             = riff_pkg::EV_LIST_START;
              res.fourcc                = w0;
              res.chunk_size            = w4;
              res.list_form             = form_last;
              res.data_position         = hpos + riff_pkg::CHUNK_HDR_LEN;
              if (stack_count < CW'(LIST_STACK_DEPTH)) begin
                push_en          = 1'b1;
                stack_count_next = stack_count + CW'(1);
              end else begin
                res.stack_overflow = 1'b1;
              end
            end
          end
          PH_DATA: begin
            payload_left_next = (payload_left != 32'd0) ? payload_left - 32'd1 : payload_left;
            res_valid         = 1'b1;
            res.event_res     = riff_pkg::EV_DATA;
            res.data_value    = b;
            if (payload_left_next == 32'd0) begin
              phase_next        = pad_pending ? PH_PAD : PH_HDR;
              res.last_of_chunk = 1'b1;
            end
          end
          PH_PAD: begin
            pad_pending_next = 1'b0;
            phase_next       = PH_HDR;
          end
          default: begin
          end
        endcase
      end
    end
    res.nesting_depth = depth_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_FILE;
      next_header_position <= '0;
      header_count         <= '0;
      payload_left         <= '0;
      pad_pending          <= 1'b0;
      stack_count          <= '0;
    end else begin
      phase                <= phase_next;
      next_header_position <= next_header_position_next;
      header_count         <= header_count_next;
      payload_left         <= payload_left_next;
      pad_pending          <= pad_pending_next;
      stack_count          <= stack_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hb_we) begin
      header_bytes[header_count] <= b;
    end
    if (push_en) begin
      list_end_stack[stack_count[IW-1:0]] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end
    end else if (res_valid) begin
      if (!m_axis_tvalid || out_fire) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (res_valid) begin
      if (!m_axis_tvalid || out_fire) begin
        out_reg <= res;
      end else begin
        skid_reg <= res;
      end
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tuser  = out_reg.event_res;
  assign m_axis_tlast  = out_reg.last_of_chunk;
  assign m_axis_tdata  = {3'b0, out_reg.stack_overflow, out_reg.data_value,
                          out_reg.nesting_depth, out_reg.data_position, out_reg.list_form,
                          out_reg.chunk_size, out_reg.fourcc};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid register full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid register filled without an output stall");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CW'(LIST_STACK_DEPTH))
    else $error("LIST stack count beyond depth");

  a_err_idle_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR) |-> (header_count == 4'd0))
    else $error("header count moving in error phase");
`endif

endmodule
